// ===== rtl/core/mavg_pkg.sv =====
// ----------------------------------------------------------------------------
// mavg_pkg
// shared constants, controller state type and the command/status structs
// between the moving average controller and datapath
// ----------------------------------------------------------------------------
`default_nettype none

package mavg_pkg;

   localparam int CSR_BITS        = 7;
   localparam int WINDOW_MAX_DEF  = 64;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF   = 8;
   localparam int WINDOW_RESET    = 4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_LOAD,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic capture;
      logic update;
      logic div_load;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic div_last;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/core/mavg_ctrl.sv =====
// ----------------------------------------------------------------------------
// mavg_ctrl
// request sequencing: capture, window update, divide, result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module mavg_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output mavg_pkg::cmd_type      cmd,
   input  mavg_pkg::status_type   status
);

   import mavg_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (status.div_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
         end
         ST_LOAD: begin
            cmd.div_load = 1'b1;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         ST_FINISH: begin
            cmd.out_load = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_accept_starts_update: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_UPDATE))
      else $error("accepted request did not start the window update");

   a_finish_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_valid_ff && !rsp_ready) |=>
      (state_ff == ST_FINISH && rsp_valid_ff))
      else $error("finished result overran a stalled response");

   a_rsp_held_until_taken: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> rsp_valid_ff)
      else $error("response dropped before it was taken");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/mavg_dp.sv =====
// ----------------------------------------------------------------------------
// mavg_dp
// sample ring store, running sum, fill count, restoring divider and
// response register of the moving average filter
// ----------------------------------------------------------------------------
`default_nettype none

module mavg_dp #(
   parameter int WINDOW_MAX  = mavg_pkg::WINDOW_MAX_DEF,
   parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEF,
   parameter int FRAC_BITS   = mavg_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic signed [SAMPLE_BITS-1:0]         req_sample,
   input  logic                                  csr_write_enable,
   input  logic [mavg_pkg::CSR_BITS-1:0]         csr_write_data,
   input  mavg_pkg::cmd_type                     cmd,
   output mavg_pkg::status_type                  status,
   output logic signed [SAMPLE_BITS+FRAC_BITS-1:0] rsp_average,
   output logic                                  rsp_window_full
);

   import mavg_pkg::*;

   localparam int PTR_BITS  = $clog2(WINDOW_MAX);
   localparam int CNT_BITS  = $clog2(WINDOW_MAX + 1);
   localparam int SUM_BITS  = SAMPLE_BITS + PTR_BITS;
   localparam int DIV_BITS  = SUM_BITS + FRAC_BITS;
   localparam int AVG_BITS  = SAMPLE_BITS + FRAC_BITS;
   localparam int DCNT_BITS = $clog2(DIV_BITS);
   localparam int WS_BITS   = (CSR_BITS > CNT_BITS) ? CSR_BITS : CNT_BITS;

   logic signed [SAMPLE_BITS-1:0] store_mem [WINDOW_MAX];

   logic [CSR_BITS-1:0]        win_size_ff;
   logic [PTR_BITS-1:0]        wp_ff;
   logic [PTR_BITS-1:0]        wp_in;
   logic [CNT_BITS-1:0]        fill_ff;
   logic [CNT_BITS-1:0]        fill_in;
   logic signed [SUM_BITS-1:0] sum_ff;
   logic signed [SUM_BITS-1:0] sum_in;
   logic                       full_ff;
   logic                       full_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic signed [SAMPLE_BITS-1:0] rd_ff;

   logic [CNT_BITS-1:0]        rem_ff;
   logic [CNT_BITS-1:0]        rem_in;
   logic [DIV_BITS-1:0]        quo_ff;
   logic [DIV_BITS-1:0]        quo_in;
   logic                       neg_ff;
   logic [DCNT_BITS-1:0]       dcnt_ff;
   logic [DCNT_BITS-1:0]       dcnt_in;

   logic signed [AVG_BITS-1:0] avg_ff;
   logic                       wfull_ff;

   logic [WS_BITS-1:0]         ws_ext;
   logic [CNT_BITS-1:0]        eff_win;
   logic [CNT_BITS:0]          wp_ext;
   logic [CNT_BITS:0]          fill_ext;
   logic [CNT_BITS:0]          oldest_wide;
   logic [PTR_BITS-1:0]        rd_addr;
   logic signed [DIV_BITS-1:0] dividend;
   logic [CNT_BITS:0]          shifted;
   logic [CNT_BITS:0]          trial;
   logic [DIV_BITS-1:0]        quo_signed;

   // effective window: zero acts as one, clamp to store depth
   always_comb begin
      ws_ext = WS_BITS'(win_size_ff);
      if (ws_ext == '0) begin
         eff_win = CNT_BITS'(1);
      end else if (ws_ext > WS_BITS'(WINDOW_MAX)) begin
         eff_win = CNT_BITS'(WINDOW_MAX);
      end else begin
         eff_win = CNT_BITS'(ws_ext);
      end
   end

   // oldest held entry, modulo store depth
   always_comb begin
      wp_ext   = (CNT_BITS+1)'(wp_ff);
      fill_ext = (CNT_BITS+1)'(fill_ff);
      if (wp_ext >= fill_ext) begin
         oldest_wide = wp_ext - fill_ext;
      end else begin
         oldest_wide = wp_ext + (CNT_BITS+1)'(WINDOW_MAX) - fill_ext;
      end
      rd_addr = oldest_wide[PTR_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         store_mem[wp_ff] <= sample_ff;
      end
      rd_ff <= store_mem[rd_addr];
   end

   // window update
   always_comb begin
      wp_in   = wp_ff;
      fill_in = fill_ff;
      sum_in  = sum_ff;
      full_in = full_ff;
      if (cmd.update) begin
         if (wp_ff == PTR_BITS'(WINDOW_MAX - 1)) begin
            wp_in = '0;
         end else begin
            wp_in = wp_ff + 1'b1;
         end
         if (fill_ff >= eff_win) begin
            sum_in  = sum_ff - SUM_BITS'(rd_ff) + SUM_BITS'(sample_ff);
            fill_in = eff_win;
         end else begin
            sum_in  = sum_ff + SUM_BITS'(sample_ff);
            fill_in = fill_ff + 1'b1;
         end
         full_in = (fill_in == eff_win);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_size_ff <= CSR_BITS'(WINDOW_RESET);
         wp_ff       <= '0;
         fill_ff     <= '0;
         sum_ff      <= '0;
      end else if (csr_write_enable) begin
         win_size_ff <= csr_write_data;
         wp_ff       <= '0;
         fill_ff     <= '0;
         sum_ff      <= '0;
      end else begin
         wp_ff   <= wp_in;
         fill_ff <= fill_in;
         sum_ff  <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      full_ff <= full_in;
      if (cmd.capture) begin
         sample_ff <= req_sample;
      end
   end

   // restoring divider, one quotient bit per cycle on the magnitude
   assign dividend = DIV_BITS'(sum_ff) <<< FRAC_BITS;
   assign shifted  = {rem_ff, quo_ff[DIV_BITS-1]};
   assign trial    = shifted - {1'b0, fill_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dcnt_in = dcnt_ff;
      if (cmd.div_load) begin
         rem_in  = '0;
         quo_in  = dividend[DIV_BITS-1] ? DIV_BITS'(-dividend) : DIV_BITS'(dividend);
         dcnt_in = '0;
      end else if (cmd.div_step) begin
         if (!trial[CNT_BITS]) begin
            rem_in = trial[CNT_BITS-1:0];
            quo_in = {quo_ff[DIV_BITS-2:0], 1'b1};
         end else begin
            rem_in = shifted[CNT_BITS-1:0];
            quo_in = {quo_ff[DIV_BITS-2:0], 1'b0};
         end
         dcnt_in = dcnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff  <= '0;
         dcnt_ff <= '0;
      end else begin
         rem_ff  <= rem_in;
         dcnt_ff <= dcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      if (cmd.div_load) begin
         neg_ff <= dividend[DIV_BITS-1];
      end
   end

   assign status.div_last = (dcnt_ff == DCNT_BITS'(DIV_BITS - 1));

   // response register
   assign quo_signed = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         avg_ff   <= quo_signed[AVG_BITS-1:0];
         wfull_ff <= full_ff;
      end
   end

   assign rsp_average     = avg_ff;
   assign rsp_window_full = wfull_ff;

`ifndef SYNTHESIS
   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_BITS'(WINDOW_MAX))
      else $error("fill count beyond store depth");

   a_csr_restarts_window: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> (fill_ff == '0 && wp_ff == '0 && sum_ff == '0))
      else $error("window size write did not restart the window");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (rem_ff < fill_ff))
      else $error("divider remainder not below fill count");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/moving_average_filter_core.sv =====
// an accepted request passes through the update, load, divide and finish states;
//   finish waits for the prior response to be taken, and only idle takes requests;
//   the restoring divider retires one quotient bit per cycle over a 30-bit dividend
// a finished response is held in its own register while the next request is taken
// reset clears control, pointer, fill count, sum and sets window size to 4;
//   the sample store is not cleared and needs no clearing pass
// ----------------------------------------------------------------------------
// moving_average_filter_core
// boxcar moving average over the most recent window_size samples
// ----------------------------------------------------------------------------
`default_nettype none

module moving_average_filter_core #(
   parameter int WINDOW_MAX  = mavg_pkg::WINDOW_MAX_DEF,
   parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEF,
   parameter int FRAC_BITS   = mavg_pkg::FRAC_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [SAMPLE_BITS-1:0]           req_sample,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [SAMPLE_BITS+FRAC_BITS-1:0] rsp_average,
   output logic                                    rsp_window_full,
   input  logic                                    csr_write_enable,
   input  logic [mavg_pkg::CSR_BITS-1:0]           csr_write_data
);

   import mavg_pkg::*;

   cmd_type    cmd;
   status_type status;

   mavg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   mavg_dp #(
      .WINDOW_MAX  (WINDOW_MAX),
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAC_BITS   (FRAC_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_sample       (req_sample),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_average      (rsp_average),
      .rsp_window_full  (rsp_window_full)
   );

endmodule

`default_nettype wire
